// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off while in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/clsrng_pkg.sv
package clsrng_pkg;

	typedef logic [30:0] word_t;

	// moduli are 2^31 minus a small fold constant
	localparam logic [31:0] MOD_ONE  = 32'd2147483563;
	localparam logic [31:0] MOD_TWO  = 32'd2147483399;
	localparam logic [7:0]  FOLD_ONE = 8'd85;
	localparam logic [7:0]  FOLD_TWO = 8'd249;
	localparam logic [15:0] MUL_ONE  = 16'd40014;
	localparam logic [15:0] MUL_TWO  = 16'd40692;

	localparam word_t GEN_ONE_RESET = 31'd1;
	localparam word_t GEN_TWO_RESET = 31'd123456789;
	localparam logic signed [32:0] WRAP_ADD = 33'sd2147483562;

	// generator select codes
	localparam logic GEN_SEL_ONE = 1'b0;
	localparam logic GEN_SEL_TWO = 1'b1;

	// warm-up steps discarded before the table starts to fill
	localparam int WARM_EXTRA = 8;

	typedef struct packed {
		logic  start;
		logic  sel;
		word_t x;
	} mm_req_t;

	typedef struct packed {
		logic  valid;
		logic  sel;
		word_t res;
	} mm_rsp_t;

endpackage

// File: sv/clsrng_mulmod.sv
`include "assert_macros.svh"

module clsrng_mulmod
	import clsrng_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	logic [46:0] prod_d;
	logic [46:0] prod_s1;
	logic        sel_s1;
	logic        vld_s1;
	logic [31:0] fold_d;
	logic [31:0] fold_s2;
	logic        sel_s2;
	logic        vld_s2;
	logic [15:0] mul;
	logic [7:0]  fold_c;
	logic [31:0] modulus;
	logic [31:0] reduced;

	// stage 1: x times multiplier
	always_comb begin
		mul    = (req.sel == GEN_SEL_TWO) ? MUL_TWO : MUL_ONE;
		prod_d = 47'(req.x) * 47'(mul);
	end

	// stage 2: fold the bits above 2^31 back in
	always_comb begin
		fold_c = (sel_s1 == GEN_SEL_TWO) ? FOLD_TWO : FOLD_ONE;
		fold_d = 32'(prod_s1[46:31]) * 32'(fold_c) + 32'(prod_s1[30:0]);
	end

	// fold stays below twice the modulus, one subtract finishes it
	always_comb begin
		modulus   = (sel_s2 == GEN_SEL_TWO) ? MOD_TWO : MOD_ONE;
		reduced   = (fold_s2 >= modulus) ? (fold_s2 - modulus) : fold_s2;
		rsp.valid = vld_s2;
		rsp.sel   = sel_s2;
		rsp.res   = reduced[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		sel_s1  <= req.sel;
		fold_s2 <= fold_d;
		sel_s2  <= sel_s1;
	end

	`ASSERT_IMP(a_res_below_mod_one, clk, arst_n, rsp.valid && (rsp.sel == GEN_SEL_ONE), 32'(rsp.res) < MOD_ONE, "generator one result not reduced")
	`ASSERT_IMP(a_res_below_mod_two, clk, arst_n, rsp.valid && (rsp.sel == GEN_SEL_TWO), 32'(rsp.res) < MOD_TWO, "generator two result not reduced")

endmodule

// File: sv/clsrng_slot.sv
module clsrng_slot
	import clsrng_pkg::*;
#(
	parameter int TABLE_SIZE = 32
)
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  word_t                         x,
	output logic                          vld,
	output logic [$clog2(TABLE_SIZE)-1:0] slot
);

	localparam longint unsigned DIV   = 64'd1 + 64'd2147483562 / 64'(TABLE_SIZE);
	localparam int              RSH   = 37;
	localparam longint unsigned RECIP = (64'd1 << RSH) / DIV;
	localparam int              RW    = $clog2(RECIP + 1);
	localparam int              PW    = 31 + RW;
	localparam int              QW    = $clog2(TABLE_SIZE + 1);
	localparam int              IW    = $clog2(TABLE_SIZE);

	logic [PW-1:0] prod_d;
	logic [PW-1:0] prod_s1;
	word_t         x_s1;
	logic          vld_s1;
	logic [QW-1:0] q_est;
	logic [31:0]   qd_d;
	logic [QW-1:0] q_s2;
	logic [31:0]   qd_s2;
	word_t         x_s2;
	logic          vld_s2;
	logic          bump;
	logic [QW-1:0] q_fix;

	// reciprocal estimate, never above the true quotient and at most one below
	always_comb begin
		prod_d = PW'(x) * PW'(RECIP[RW-1:0]);
		q_est  = QW'(prod_s1 >> RSH);
		qd_d   = 32'(q_est) * 32'(DIV[30:0]);
	end

	// one correction step, then clamp to the top slot
	always_comb begin
		bump  = (32'(x_s2) >= (qd_s2 + 32'(DIV[30:0])));
		q_fix = q_s2 + QW'(bump);
		slot  = (q_fix >= QW'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : q_fix[IW-1:0];
		vld   = vld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		x_s1    <= x;
		q_s2    <= q_est;
		qd_s2   <= qd_d;
		x_s2    <= x_s1;
	end

endmodule

// File: sv/combined_lcg_shuffle_rng.sv
// channel  | handshake            | payload
// ---------+----------------------+----------------------------
// input    | in_valid / in_stall  | cmd (1), seed_value (31)
// output   | out_valid / out_stall| deviate (31)
//
// a draw beat steps through DRAW_A to DRAW_E and back to idle before the next input beat can be taken
// a reseed beat runs TABLE_SIZE + 8 warm-up steps and then a draw: each warm-up step waits for
// the two-stage shared modular multiplier before the next step can issue
// reset gives an unseeded start: generators 1 and 123456789, table zero via valid bits
// the output register only holds the block under stall once a second result is ready

`include "assert_macros.svh"

module combined_lcg_shuffle_rng
	import clsrng_pkg::*;
#(
	parameter int TABLE_SIZE = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [30:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] deviate
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int SW = $clog2(TABLE_SIZE + WARM_EXTRA);

	// sequencer states
	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_WARM_ISSUE = 3'd1;
	localparam logic [2:0] ST_WARM_WAIT  = 3'd2;
	localparam logic [2:0] ST_DRAW_A     = 3'd3;
	localparam logic [2:0] ST_DRAW_B     = 3'd4;
	localparam logic [2:0] ST_DRAW_C     = 3'd5;
	localparam logic [2:0] ST_DRAW_D     = 3'd6;
	localparam logic [2:0] ST_DRAW_E     = 3'd7;

	logic [2:0]            state_q;
	word_t                 first_gen_q;
	word_t                 second_gen_q;
	word_t                 last_out_q;
	logic [SW-1:0]         step_q;
	logic [IW-1:0]         slot_q;
	word_t                 rd_q;
	logic                  rd_vld_q;
	logic [TABLE_SIZE-1:0] tbl_vld_q;
	word_t                 shuf_mem [TABLE_SIZE];
	logic                  out_valid_q;
	word_t                 deviate_q;

	mm_req_t               mm_req;
	mm_rsp_t               mm_rsp;
	logic                  slot_vld;
	logic [IW-1:0]         slot_idx;

	logic                  in_take;
	word_t                 seed_fix;
	logic                  warm_fill;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	word_t                 wr_data;
	word_t                 rd_word;
	logic signed [32:0]    diff;
	logic signed [32:0]    wrapped;
	word_t                 dev_next;
	logic                  out_load;

	// shared modular multiplier, serves both generators
	clsrng_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	// slot picker runs alongside the two generator steps of a draw
	clsrng_slot #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_slot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DRAW_A),
		.x      (last_out_q),
		.vld    (slot_vld),
		.slot   (slot_idx)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign seed_fix  = (seed_value == '0) ? 31'd1 : seed_value;
	assign out_valid = out_valid_q;
	assign deviate   = deviate_q;

	// multiplier requests: generator one while warming and first in a draw, then two
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.sel   = GEN_SEL_ONE;
		mm_req.x     = first_gen_q;
		unique case (state_q) inside
			ST_WARM_ISSUE, ST_DRAW_A: begin
				mm_req.start = 1'b1;
			end
			ST_DRAW_B: begin
				mm_req.start = 1'b1;
				mm_req.sel   = GEN_SEL_TWO;
				mm_req.x     = second_gen_q;
			end
			default: begin
				mm_req.start = 1'b0;
			end
		endcase
	end

	// table write: warm-up fills from the top slot down, a draw refills its slot
	always_comb begin
		warm_fill = (state_q == ST_WARM_WAIT) && mm_rsp.valid
			&& (step_q < SW'(TABLE_SIZE));
		wr_en     = warm_fill || (state_q == ST_DRAW_D);
		wr_addr   = (state_q == ST_DRAW_D) ? slot_q : step_q[IW-1:0];
		wr_data   = (state_q == ST_DRAW_D) ? first_gen_q : mm_rsp.res;
	end

	// slot minus generator two, wrapped back into range when below one
	always_comb begin
		rd_word  = rd_vld_q ? rd_q : '0;
		diff     = $signed({2'b00, rd_word}) - $signed({2'b00, second_gen_q});
		wrapped  = (diff < 33'sd1) ? (diff + WRAP_ADD) : diff;
		dev_next = wrapped[30:0];
		out_load = (state_q == ST_DRAW_E) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_gen_q  <= GEN_ONE_RESET;
			second_gen_q <= GEN_TWO_RESET;
			last_out_q   <= '0;
			step_q       <= '0;
			tbl_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				tbl_vld_q[wr_addr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (cmd) begin
							first_gen_q  <= seed_fix;
							second_gen_q <= seed_fix;
							step_q       <= SW'(TABLE_SIZE + WARM_EXTRA - 1);
							state_q      <= ST_WARM_ISSUE;
						end else begin
							state_q <= ST_DRAW_A;
						end
					end
				end
				ST_WARM_ISSUE: begin
					state_q <= ST_WARM_WAIT;
				end
				ST_WARM_WAIT: begin
					if (mm_rsp.valid) begin
						first_gen_q <= mm_rsp.res;
						if (step_q == '0) begin
							// slot 0 seeds the first slot pick
							last_out_q <= mm_rsp.res;
							state_q    <= ST_DRAW_A;
						end else begin
							step_q  <= step_q - SW'(1);
							state_q <= ST_WARM_ISSUE;
						end
					end
				end
				ST_DRAW_A: begin
					state_q <= ST_DRAW_B;
				end
				ST_DRAW_B: begin
					state_q <= ST_DRAW_C;
				end
				ST_DRAW_C: begin
					first_gen_q <= mm_rsp.res;
					slot_q      <= slot_idx;
					state_q     <= ST_DRAW_D;
				end
				ST_DRAW_D: begin
					second_gen_q <= mm_rsp.res;
					state_q      <= ST_DRAW_E;
				end
				ST_DRAW_E: begin
					if (out_load) begin
						last_out_q <= dev_next;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shuffle table storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			shuf_mem[wr_addr] <= wr_data;
		end
		if (state_q == ST_DRAW_C) begin
			rd_q     <= shuf_mem[slot_idx];
			rd_vld_q <= tbl_vld_q[slot_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			deviate_q <= dev_next;
		end
	end

	`ASSERT_IMP(a_gen_one_on_time, clk, arst_n, state_q == ST_DRAW_C, mm_rsp.valid && (mm_rsp.sel == GEN_SEL_ONE) && slot_vld, "generator one or slot not ready for table read")
	`ASSERT_IMP(a_gen_two_on_time, clk, arst_n, state_q == ST_DRAW_D, mm_rsp.valid && (mm_rsp.sel == GEN_SEL_TWO), "generator two not ready for combine")
	`ASSERT_NXT(a_deviate_nonzero, clk, arst_n, out_load, deviate_q != '0, "deviate left the range above zero")

endmodule

// File: verif/tb.sv
module tb;
	import clsrng_pkg::*;

	localparam int TABLE_SIZE = 32;
	localparam int RANDOM_ITEMS = 1200;
	// no beat on either channel for this many cycles means the block has hung
	localparam int QUIET_LIMIT = 1000;
	// drain time after the last deviate, longer than a full reseed
	localparam int TAIL_CYCLES = 200;
	localparam int MAX_REPORTS = 10;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	// slot index divisor and the wrap added to a difference below one
	localparam int unsigned SLOT_SPAN = 1 + (MOD_ONE - 32'd1) / TABLE_SIZE;
	localparam longint WRAP_SUM = 64'(MOD_ONE) - 1;

	typedef struct {
		logic  cmd;
		word_t seed;
		bit    drain_first;
	} rng_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = CMD_DRAW;
	logic [30:0] seed_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] deviate;

	combined_lcg_shuffle_rng #(
		.TABLE_SIZE(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.deviate(deviate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the generator state, advanced on every accepted input beat
	word_t gen_a = GEN_ONE_RESET;
	word_t gen_b = GEN_TWO_RESET;
	word_t prev_dev = '0;
	word_t shuffle [TABLE_SIZE];

	rng_req_t pending_q [$];
	word_t    deviate_q [$];

	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;
	int send_gap = 0;
	int hold_cnt = 0;

	int faults = 0;
	int quiet_cycles = 0;
	int accepted_items = 0;
	int draws_seen = 0;
	int reseeds_seen = 0;
	int results_seen = 0;
	int total_items = 0;

	// exact product reduced by the modulus, so seeds above a modulus fold on the first step
	function automatic word_t mulmod_step(word_t x, logic [15:0] mul, logic [31:0] modulus);
		logic [63:0] prod;
		prod = 64'(x) * 64'(mul);
		return word_t'(prod % 64'(modulus));
	endfunction

	function automatic word_t predict_deviate(logic op, word_t seed);
		word_t g;
		int k;
		int unsigned slot;
		longint diff;
		if (op == CMD_RESEED) begin
			// zero seed behaves as one; both generators start from the seed
			g = (seed == '0) ? word_t'(1) : seed;
			gen_b = g;
			// first eight warm-up values are thrown away, the rest fill the table top down
			for (k = TABLE_SIZE + 7; k >= 0; k--) begin
				g = mulmod_step(g, MUL_ONE, MOD_ONE);
				if (k < TABLE_SIZE)
					shuffle[k] = g;
			end
			gen_a = g;
			prev_dev = shuffle[0];
		end
		gen_a = mulmod_step(gen_a, MUL_ONE, MOD_ONE);
		gen_b = mulmod_step(gen_b, MUL_TWO, MOD_TWO);
		slot = prev_dev / SLOT_SPAN;
		if (slot >= TABLE_SIZE)
			slot = TABLE_SIZE - 1;
		diff = longint'(shuffle[slot]) - longint'(gen_b);
		shuffle[slot] = gen_a;
		if (diff < 1)
			diff += WRAP_SUM;
		prev_dev = word_t'(diff);
		return prev_dev;
	endfunction

	function automatic void add_req(logic op, word_t seed, bit drain_first);
		rng_req_t r;
		r.cmd = op;
		r.seed = seed;
		r.drain_first = drain_first;
		pending_q.push_back(r);
	endfunction

	task automatic note_fault(string what);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("[%0t] fault: %s", $time, what);
	endtask

	// seeds worth hitting: degenerate, top of range and past both moduli
	function automatic word_t corner_seed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return word_t'(1);
			2: return word_t'(MOD_ONE) + word_t'($urandom_range(0, 84));
			3: return word_t'(MOD_TWO) + word_t'($urandom_range(0, 2)) - word_t'(1);
			4: return word_t'(MOD_ONE) - word_t'(1);
			default: return '1;
		endcase
	endfunction

	// sampling side: both channels are looked at on the rising edge, before the block updates
	always @(posedge clk) begin : monitor
		word_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				in_took = 1'b1;
				moved = 1'b1;
				accepted_items++;
				deviate_q.push_back(predict_deviate(cmd, seed_value));
				if (cmd == CMD_RESEED)
					reseeds_seen++;
				else
					draws_seen++;
			end
			if (out_valid && !out_stall) begin
				out_took = 1'b1;
				moved = 1'b1;
				results_seen++;
				if (deviate_q.size() == 0) begin
					note_fault($sformatf("unexpected deviate %0d", deviate));
				end else begin
					want = deviate_q.pop_front();
					if (deviate !== want)
						note_fault($sformatf("deviate expected %0d got %0d", want, deviate));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	// input beats change on the falling edge; valid is written once per edge
	always @(negedge clk) begin : driver
		logic drive_v;
		rng_req_t next_req;
		drive_v = in_valid;
		if (in_took) begin
			in_took = 1'b0;
			drive_v = 1'b0;
			send_gap = in_burst ? 0 : $urandom_range(0, 13);
			// switch between back-to-back runs and gappy traffic now and then
			if ($urandom_range(0, 39) == 0)
				in_burst = !in_burst;
		end
		if (arst_n && !drive_v) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_q.size() > 0 &&
					!(pending_q[0].drain_first && deviate_q.size() > 0)) begin
				next_req = pending_q.pop_front();
				cmd <= next_req.cmd;
				seed_value <= next_req.seed;
				drive_v = 1'b1;
			end
		end
		in_valid <= drive_v;
	end

	// receiver back-pressure, redrawn after every output beat
	always @(negedge clk) begin : receiver
		if (out_took) begin
			out_took = 1'b0;
			hold_cnt = out_burst ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 39) == 0)
				out_burst = !out_burst;
		end
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		int n;
		word_t s;
		for (n = 0; n < TABLE_SIZE; n++)
			shuffle[n] = '0;

		// draws straight out of reset: empty table, so every difference wraps
		add_req(CMD_DRAW, '0, 1'b0);
		add_req(CMD_DRAW, '1, 1'b0);
		add_req(CMD_DRAW, 31'h2AAAAAAA, 1'b0);
		// zero seed acts as one
		add_req(CMD_RESEED, '0, 1'b0);
		add_req(CMD_DRAW, 31'h55555555, 1'b0);
		add_req(CMD_RESEED, word_t'(1), 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		// top of the seed range and the all-ones seed past the first modulus
		add_req(CMD_RESEED, word_t'(MOD_ONE) - word_t'(1), 1'b0);
		add_req(CMD_RESEED, '1, 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		// seed equal to a modulus collapses that generator to zero
		add_req(CMD_RESEED, word_t'(MOD_ONE), 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		add_req(CMD_DRAW, '1, 1'b0);
		add_req(CMD_RESEED, word_t'(MOD_TWO), 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		add_req(CMD_RESEED, 31'h2AAAAAAA, 1'b0);
		add_req(CMD_RESEED, 31'h55555555, 1'b0);
		add_req(CMD_DRAW, '1, 1'b0);
		add_req(CMD_RESEED, word_t'(GEN_TWO_RESET), 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);
		add_req(CMD_DRAW, '0, 1'b0);

		// random traffic: mostly draws, a reseed about one beat in ten,
		// an occasional full drain before a beat goes out
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				s = ($urandom_range(0, 3) == 0) ? corner_seed() : word_t'($urandom);
				add_req(CMD_RESEED, s, n == 0 || $urandom_range(0, 49) == 0);
			end else begin
				add_req(CMD_DRAW, word_t'($urandom), n == 0 || $urandom_range(0, 99) == 0);
			end
		end
		total_items = pending_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(accepted_items == total_items && deviate_q.size() == 0) &&
				quiet_cycles < QUIET_LIMIT)
			@(negedge clk);

		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat moved for %0d cycles, %0d of %0d input beats taken",
				$time, QUIET_LIMIT, accepted_items, total_items);
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (deviate_q.size() != 0)
				note_fault($sformatf("%0d deviates never arrived", deviate_q.size()));
			$display("covered %0d draws and %0d reseeds (zero, modulus and over-range seeds too)",
				draws_seen, reseeds_seen);
			$display("%0d deviates checked under random gaps and stalls, %0d faults",
				results_seen, faults);
			if (faults == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/clsrng_pkg.sv
sv/clsrng_mulmod.sv
sv/clsrng_slot.sv
sv/combined_lcg_shuffle_rng.sv
verif/tb.sv
